>>> rtl/sss_pkg.sv
// Package: item types and widths for the sample set statistics block.
`timescale 1ns / 1ps
package sss_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned CountBits  = 5;
  localparam int unsigned StatBits   = 24;
  localparam int unsigned StatusBits = 2;

  localparam logic [StatusBits-1:0] StatusOk      = 2'd0;
  localparam logic [StatusBits-1:0] StatusSingle  = 2'd1;
  localparam logic [StatusBits-1:0] StatusDropped = 2'd2;

  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic                  last_sample;
  } sss_in_t;

  typedef struct packed {
    logic [CountBits-1:0]  sample_count;
    logic [StatBits-1:0]   mean_value;
    logic [StatBits-1:0]   median_value;
    logic [StatBits-1:0]   std_deviation;
    logic [StatusBits-1:0] status_code;
  } sss_out_t;

endpackage

>>> rtl/sample_set_statistics_top.sv
// Sequence: for N kept samples the closing item's result follows bubble sort passes of N-1
//   compares, a prep state, a 58-step divider run twice, a 29-step root and an output state.
// Throughput: one loading item per cycle; from the closing item on no item is taken until the
//   result is accepted; both divisions share one subtract/compare unit, the root has its own.
// Reset: rst_ni clears sequencer, count, sums and output valid; the store is left as is.
`timescale 1ns / 1ps
module sample_set_statistics_top
  import sss_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sss_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sss_out_t out_data_o
);

  localparam int unsigned IdxBits  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned NBits    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumBits  = SampleBits + NBits;
  localparam int unsigned SqBits   = 2 * SampleBits + NBits;
  // Dividend width for the variance quotient (65536 * numerator).
  localparam int unsigned DivBits  = SqBits + NBits + 16;
  localparam int unsigned StepBits = $clog2(DivBits + 1);

  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StSort  = 3'd1;
  localparam logic [2:0] StPrep  = 3'd2;
  localparam logic [2:0] StMean  = 3'd3;
  localparam logic [2:0] StVar   = 3'd4;
  localparam logic [2:0] StRoot  = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] state_q, state_d;

  logic [SampleBits-1:0] store_q [MAX_SAMPLES];
  logic [NBits-1:0]   kept_q;
  logic [SumBits-1:0] sum_q;
  logic [SqBits-1:0]  sq_q;
  logic               ovf_q;

  logic [IdxBits-1:0]  pos_q;
  logic                swapped_q;
  logic [DivBits-1:0]  rem_q, quo_q, div_q;
  logic [DivBits-1:0]  den_q;
  logic [StepBits-1:0] step_q;
  logic [StatBits-1:0] mean_q, med_q, dev_q;
  logic                out_valid_q;
  sss_out_t            out_q;

  logic take, keep;
  assign in_ready_o = (state_q == StLoad) && !out_valid_q;
  assign take = in_valid_i && in_ready_o;
  assign keep = take && (kept_q < NBits'(MAX_SAMPLES));

  // Shared restoring step: shift in the next dividend bit, trial subtract.
  logic [DivBits:0]   trial_rem;
  logic [DivBits:0]   trial_diff;
  logic               trial_ok;
  assign trial_rem  = {rem_q, div_q[DivBits-1]};
  assign trial_diff = trial_rem - {1'b0, den_q};
  assign trial_ok   = !trial_diff[DivBits];

  // Root step: remainder grows by two bits, test 4*root+1.
  logic [DivBits+1:0] root_rem, root_test, root_diff;
  assign root_rem  = {rem_q, div_q[DivBits-1 -: 2]};
  assign root_test = {quo_q, 2'b01};
  assign root_diff = root_rem - root_test;

  logic [IdxBits-1:0] pos_nx;
  assign pos_nx = pos_q + 1'b1;
  logic [IdxBits-1:0] mid_hi, mid_lo;
  assign mid_hi = IdxBits'(kept_q >> 1);
  assign mid_lo = mid_hi - 1'b1;

  // Store: written on load, swapped pairwise during the sort passes.
  always_ff @(posedge clk_i) begin
    if (keep) begin
      store_q[kept_q[IdxBits-1:0]] <= in_data_i.sample;
    end else if (state_q == StSort && kept_q >= NBits'(2) &&
                 store_q[pos_q] > store_q[pos_nx]) begin
      store_q[pos_q]  <= store_q[pos_nx];
      store_q[pos_nx] <= store_q[pos_q];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad: if (take && in_data_i.last_sample) state_d = StSort;
      StSort: begin
        if (32'(pos_nx) + 1 >= 32'(kept_q) || kept_q < NBits'(2)) begin
          state_d = (swapped_q || (store_q[pos_q] > store_q[pos_nx] &&
                     kept_q >= NBits'(2))) ? StSort : StPrep;
        end
      end
      StPrep: state_d = StMean;
      StMean: if (step_q == StepBits'(DivBits - 1)) state_d = StVar;
      StVar:  if (step_q == StepBits'(DivBits - 1)) state_d = StRoot;
      StRoot: if (step_q == StepBits'(DivBits / 2 - 1)) state_d = StOut;
      StOut:  state_d = StLoad;
      default: state_d = StLoad;
    endcase
  end

  logic [SumBits+SumBits-1:0] sum_sq;
  logic [SqBits+NBits-1:0]    n_sq;
  assign sum_sq = sum_q * sum_q;
  assign n_sq   = sq_q * kept_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      kept_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      swapped_q   <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StLoad: begin
          if (keep) begin
            kept_q <= kept_q + 1'b1;
            sum_q  <= sum_q + SumBits'(in_data_i.sample);
            sq_q   <= sq_q + SqBits'(in_data_i.sample) * SqBits'(in_data_i.sample);
          end else if (take) begin
            ovf_q <= 1'b1;
          end
          pos_q     <= '0;
          swapped_q <= 1'b0;
        end
        StSort: begin
          if (state_d == StSort && (32'(pos_nx) + 1 >= 32'(kept_q))) begin
            pos_q     <= '0;
            swapped_q <= 1'b0;
          end else begin
            pos_q <= pos_nx;
            if (store_q[pos_q] > store_q[pos_nx]) swapped_q <= 1'b1;
          end
        end
        StPrep: begin
          // Mean: (512*sum + n) / (2n).
          rem_q  <= '0;
          quo_q  <= '0;
          div_q  <= DivBits'({sum_q, 9'd0}) + DivBits'(kept_q);
          den_q  <= DivBits'({kept_q, 1'b0});
          step_q <= '0;
          if (kept_q[0]) med_q <= StatBits'({store_q[mid_hi], 8'd0});
          else med_q <= StatBits'({({1'b0, store_q[mid_lo]} +
                                    {1'b0, store_q[mid_hi]}), 7'd0});
        end
        StMean: begin
          if (step_q == StepBits'(DivBits - 1)) begin
            mean_q <= StatBits'({quo_q[DivBits-2:0], trial_ok});
            rem_q  <= '0;
            quo_q  <= '0;
            div_q  <= DivBits'({(DivBits'(n_sq) - DivBits'(sum_sq)), 16'd0});
            den_q  <= DivBits'(kept_q) * DivBits'(kept_q - 1'b1);
            step_q <= '0;
          end else begin
            rem_q  <= trial_ok ? trial_diff[DivBits-1:0] : trial_rem[DivBits-1:0];
            quo_q  <= {quo_q[DivBits-2:0], trial_ok};
            div_q  <= {div_q[DivBits-2:0], 1'b0};
            step_q <= step_q + 1'b1;
          end
        end
        StVar: begin
          if (step_q == StepBits'(DivBits - 1)) begin
            div_q  <= {quo_q[DivBits-2:0], trial_ok};
            rem_q  <= '0;
            quo_q  <= '0;
            step_q <= '0;
          end else begin
            rem_q  <= trial_ok ? trial_diff[DivBits-1:0] : trial_rem[DivBits-1:0];
            quo_q  <= {quo_q[DivBits-2:0], trial_ok};
            div_q  <= {div_q[DivBits-2:0], 1'b0};
            step_q <= step_q + 1'b1;
          end
        end
        StRoot: begin
          if (!root_diff[DivBits+1]) begin
            rem_q <= root_diff[DivBits-1:0];
            quo_q <= {quo_q[DivBits-2:0], 1'b1};
          end else begin
            rem_q <= root_rem[DivBits-1:0];
            quo_q <= {quo_q[DivBits-2:0], 1'b0};
          end
          div_q  <= {div_q[DivBits-3:0], 2'b00};
          step_q <= step_q + 1'b1;
          if (step_q == StepBits'(DivBits / 2 - 1))
            dev_q <= StatBits'({quo_q[DivBits-2:0], !root_diff[DivBits+1]});
        end
        StOut: begin
          out_valid_q        <= 1'b1;
          out_q.sample_count <= CountBits'(kept_q);
          out_q.mean_value   <= mean_q;
          out_q.median_value <= med_q;
          out_q.std_deviation <= (kept_q < NBits'(2)) ? '0 : dev_q;
          out_q.status_code  <= (kept_q < NBits'(2)) ? StatusSingle :
                                (ovf_q ? StatusDropped : StatusOk);
          kept_q <= '0;
          sum_q  <= '0;
          sq_q   <= '0;
          ovf_q  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StLoad |-> !in_ready_o) else $error("item taken while busy");
  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= NBits'(MAX_SAMPLES)) else $error("kept count beyond capacity");
  a_out_after_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StOut) else $error("stray result");

endmodule

>>> verif/tb_sample_set_statistics_top.sv
// Testbench for the sample set statistics block: predicted set results checked result by result.
`timescale 1ns / 1ps
module tb_sample_set_statistics_top;
  import sss_pkg::*;

  localparam int unsigned SetCap    = 16;
  localparam int unsigned StallLimit = 20000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  sss_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  sss_out_t out_data_o;

  sample_set_statistics_top #(.MAX_SAMPLES(SetCap)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock: 4 ns period.
  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Predictor state: a private copy of the set being loaded.
  logic [SampleBits-1:0] set_values [SetCap];
  int unsigned           set_kept;
  logic [63:0]           set_sum;
  logic [63:0]           set_sq_sum;
  bit                    set_dropped;

  sss_out_t pending_stats [$];

  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          recv_hold;
  int unsigned idle_cycles;

  // Integer square root, floored, by the digit-by-digit method.
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitpos;
    root   = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v    = v - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  // Fold one accepted item into the set; on a closing item queue the set's statistics.
  task automatic predict_set_stats(input sss_in_t item);
    logic [SampleBits-1:0] ordered [SetCap];
    logic [SampleBits-1:0] tmp;
    logic [63:0]           n;
    logic [63:0]           spread;
    sss_out_t              stats;
    if (set_kept < SetCap) begin
      set_values[set_kept] = item.sample;
      set_kept++;
      set_sum    += item.sample;
      set_sq_sum += 64'(item.sample) * 64'(item.sample);
    end else begin
      set_dropped = 1'b1;
    end
    if (!item.last_sample) return;
    n = set_kept;
    for (int i = 0; i < SetCap; i++) ordered[i] = set_values[i];
    for (int i = 1; i < set_kept; i++) begin
      for (int j = i; j > 0 && ordered[j-1] > ordered[j]; j--) begin
        tmp          = ordered[j];
        ordered[j]   = ordered[j-1];
        ordered[j-1] = tmp;
      end
    end
    stats.sample_count = CountBits'(n);
    stats.mean_value   = StatBits'((512 * set_sum + n) / (2 * n));
    if (n[0])
      stats.median_value = StatBits'(256 * 64'(ordered[n/2]));
    else
      stats.median_value = StatBits'(128 * (64'(ordered[n/2-1]) + 64'(ordered[n/2])));
    if (n < 2) begin
      stats.std_deviation = '0;
      stats.status_code   = StatusSingle;
    end else begin
      spread = n * set_sq_sum - set_sum * set_sum;
      stats.std_deviation = StatBits'(floor_root((65536 * spread) / (n * (n - 1))));
      stats.status_code   = set_dropped ? StatusDropped : StatusOk;
    end
    pending_stats.push_back(stats);
    set_kept    = 0;
    set_sum     = 0;
    set_sq_sum  = 0;
    set_dropped = 1'b0;
  endtask

  // Offer one item on the falling edge, hold it until accepted.
  task automatic send_sample(input logic [SampleBits-1:0] value, input bit closing);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i            = 1'b1;
    in_data_i.sample      = value;
    in_data_i.last_sample = closing;
    do @(posedge clk_i); while (!in_ready_o);
    predict_set_stats('{sample: value, last_sample: closing});
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (pending_stats.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random ready, or a hard hold while recv_hold is set.
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    sss_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_stats.size() == 0) begin
        $error("result with nothing expected: %p", out_data_o);
        fail_count++;
      end else begin
        want = pending_stats.pop_front();
        if (out_data_o.sample_count !== want.sample_count) begin
          $error("sample_count expected %0d got %0d", want.sample_count,
                 out_data_o.sample_count);
          fail_count++;
        end
        if (out_data_o.mean_value !== want.mean_value) begin
          $error("mean_value expected %0d got %0d", want.mean_value, out_data_o.mean_value);
          fail_count++;
        end
        if (out_data_o.median_value !== want.median_value) begin
          $error("median_value expected %0d got %0d", want.median_value,
                 out_data_o.median_value);
          fail_count++;
        end
        if (out_data_o.std_deviation !== want.std_deviation) begin
          $error("std_deviation expected %0d got %0d", want.std_deviation,
                 out_data_o.std_deviation);
          fail_count++;
        end
        if (out_data_o.status_code !== want.status_code) begin
          $error("status_code expected %0d got %0d", want.status_code,
                 out_data_o.status_code);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Directed: field extremes, single sample, even and odd median, full store and drops.
  task automatic test_directed_sets();
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0003, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0002, 1'b1);
    for (int i = 0; i < 18; i++) send_sample(16'(i * 3855), i == 17);
  endtask

  // Random sets of mostly small sizes, a few full or overflowing.
  task automatic test_random_sets(input int unsigned item_budget);
    int unsigned done;
    int unsigned len;
    logic [SampleBits-1:0] base;
    done = 0;
    while (done < item_budget) begin
      case ($urandom_range(9))
        0:       len = $urandom_range(17, 20);
        1:       len = 16;
        default: len = $urandom_range(1, 8);
      endcase
      base = 16'($urandom);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(1)) send_sample(16'($urandom), i == len - 1);
        else send_sample(base ^ 16'($urandom_range(255)), i == len - 1);
      end
      done += len;
    end
  endtask

  // Receiver holds off while the sender keeps offering sets, forcing a stall.
  task automatic test_output_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (3000) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      for (int s = 0; s < 6; s++)
        for (int i = 0; i < 4; i++) send_sample(16'($urandom), i == 3);
    join
    wait_results_drained();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    recv_hold   = 1'b0;
    fail_count  = 0;
    items_sent  = 0;
    results_seen = 0;
    idle_cycles = 0;
    set_kept    = 0;
    set_sum     = 0;
    set_sq_sum  = 0;
    set_dropped = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 85;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_sets();
    test_random_sets(150);
    // Pause the sender until every expected result has come.
    wait_results_drained();
    send_idle_pct = 85;
    recv_idle_pct = 31;
    test_random_sets(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_sets(100);

    wait_results_drained();
    repeat (400) @(negedge clk_i);
    $display("Covered %0d items in %0d sets: single, even/odd median, full store, drops,",
             items_sent, results_seen);
    $display("and long output stalls under three idling patterns.");
    if (fail_count == 0 && pending_stats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
